// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the circular queue RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked at every rising clock edge outside reset
`define CQS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define CQS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define CQS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/cqs_pkg.sv -----
// ----------------------------------------------------------------------------
// cqs_pkg
// Types, constants and index helpers of the circular queue with search
// ----------------------------------------------------------------------------
`default_nettype none

package cqs_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int FUNC_W     = 2;
  localparam int STATUS_W   = 3;
  localparam int SIZE_W     = 5;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [DATA_WIDTH-1:0] data_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH   = 2'd0,
    FUNC_POP    = 2'd1,
    FUNC_SEARCH = 2'd2
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 3'd0,
    STATUS_OVERFLOW  = 3'd1,
    STATUS_UNDERFLOW = 3'd2,
    STATUS_EMPTY     = 3'd3,
    STATUS_NOTFOUND  = 3'd4
  } status_e;

  // next ring slot, wrapping at the capacity in use
  function automatic idx_t advance(idx_t idx, cnt_t size);
    cnt_t nx;
    nx = CNT_W'(idx) + CNT_W'(1);
    if (nx >= size) begin
      advance = '0;
    end else begin
      advance = nx[IDX_W-1:0];
    end
  endfunction

  // written size saturated to 1..DEPTH
  function automatic cnt_t eff_size(logic [SIZE_W-1:0] raw);
    if (raw == '0) begin
      eff_size = CNT_W'(1);
    end else if (int'(raw) > DEPTH) begin
      eff_size = CNT_W'(DEPTH);
    end else begin
      eff_size = CNT_W'(raw);
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/cqs_ring.sv -----
// ----------------------------------------------------------------------------
// cqs_ring
// Ring storage: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module cqs_ring (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire cqs_pkg::idx_t waddr_i,
  input  wire cqs_pkg::data_t wdata_i,
  input  wire cqs_pkg::idx_t raddr_i,
  output cqs_pkg::data_t     rdata_o
);
  import cqs_pkg::*;

  data_t mem [DEPTH];
  data_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/circular_queue_with_search.sv -----
// Sequence: push, failed pop and empty search load the result state, then the output register;
//   pop first reads the ring in ST_POP; search scans in ST_SEARCH until a match or count entries compared.
// Throughput: one transaction at a time, the next accepted after the result loads; the search
//   compares one stored entry per cycle through the ring read port and one comparator.
// Reset: async active low; queue empty, capacity 16, no result pending, storage kept.
// ----------------------------------------------------------------------------
// circular_queue_with_search
// Ring-buffer FIFO with push, pop and linear search from oldest to newest
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module circular_queue_with_search (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [cqs_pkg::SIZE_W-1:0]     cfg_queue_size_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [cqs_pkg::FUNC_W-1:0]     in_func_i,
  input  wire logic signed [cqs_pkg::DATA_WIDTH-1:0] in_value_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [cqs_pkg::STATUS_W-1:0]        out_status_o,
  output logic signed [cqs_pkg::DATA_WIDTH-1:0] out_data_o,
  output logic [cqs_pkg::CNT_W-1:0]           out_position_o,
  output logic [cqs_pkg::CNT_W-1:0]           out_occupancy_o
);
  import cqs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_SEARCH,
    ST_RESULT
  } state_e;

  state_e  state_q, state_d;
  cnt_t    size_q, size_d;
  idx_t    head_q, head_d;
  idx_t    tail_q, tail_d;
  cnt_t    count_q, count_d;
  idx_t    scan_q, scan_d;
  cnt_t    iss_k_q, iss_k_d;
  cnt_t    cmp_k_q, cmp_k_d;
  logic    cmp_vld_q, cmp_vld_d;
  data_t   key_q, key_d;
  status_e res_status_q, res_status_d;
  data_t   res_data_q, res_data_d;
  cnt_t    res_pos_q, res_pos_d;
  logic    out_valid_q, out_valid_d;
  logic    out_load;
  status_e out_status_q;
  data_t   out_data_q;
  cnt_t    out_pos_q;
  cnt_t    out_occ_q;

  logic    in_fire;
  logic    cfg_fire;
  logic    mem_we;
  idx_t    mem_waddr;
  idx_t    mem_raddr;
  data_t   mem_rdata;

  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_ready_o  = (state_q == ST_IDLE) && !cfg_valid_i;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign in_fire     = in_valid_i && in_ready_o;

  cqs_ring u_ring (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (data_t'(in_value_i)),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // during idle the read port prefetches the next entry to pop
  assign mem_raddr = (state_q == ST_SEARCH) ? scan_q : advance(head_q, size_q);
  assign mem_waddr = advance(tail_q, size_q);

  always_comb begin
    state_d      = state_q;
    size_d       = size_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    scan_d       = scan_q;
    iss_k_d      = iss_k_q;
    cmp_k_d      = cmp_k_q;
    cmp_vld_d    = cmp_vld_q;
    key_d        = key_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    res_pos_d    = res_pos_q;
    mem_we       = 1'b0;
    out_load     = 1'b0;
    out_valid_d  = out_valid_q && !out_ready_i;

    case (state_q)
      ST_IDLE: begin
        if (cfg_fire) begin
          size_d  = eff_size(cfg_queue_size_i);
          head_d  = '0;
          tail_d  = '0;
          count_d = '0;
        end else if (in_fire) begin
          res_status_d = STATUS_OK;
          res_data_d   = '0;
          res_pos_d    = '0;
          state_d      = ST_RESULT;
          case (func_e'(in_func_i))
            FUNC_PUSH: begin
              if (count_q >= size_q) begin
                res_status_d = STATUS_OVERFLOW;
              end else begin
                mem_we  = 1'b1;
                tail_d  = mem_waddr;
                count_d = count_q + CNT_W'(1);
              end
            end
            FUNC_POP: begin
              if (count_q == '0) begin
                res_status_d = STATUS_UNDERFLOW;
              end else begin
                head_d  = advance(head_q, size_q);
                count_d = count_q - CNT_W'(1);
                state_d = ST_POP;
              end
            end
            FUNC_SEARCH: begin
              if (count_q == '0) begin
                res_status_d = STATUS_EMPTY;
              end else begin
                key_d     = data_t'(in_value_i);
                scan_d    = advance(head_q, size_q);
                iss_k_d   = '0;
                cmp_vld_d = 1'b0;
                state_d   = ST_SEARCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_POP: begin
        res_data_d = mem_rdata;
        state_d    = ST_RESULT;
      end
      ST_SEARCH: begin
        // read of slot scan_q is issued while the previous slot is compared
        if (cmp_vld_q && (mem_rdata == key_q)) begin
          res_status_d = STATUS_OK;
          res_pos_d    = cmp_k_q + CNT_W'(1);
          state_d      = ST_RESULT;
        end else if (cmp_vld_q && ((cmp_k_q + CNT_W'(1)) == count_q)) begin
          res_status_d = STATUS_NOTFOUND;
          state_d      = ST_RESULT;
        end else begin
          scan_d    = advance(scan_q, size_q);
          cmp_k_d   = iss_k_q;
          iss_k_d   = iss_k_q + CNT_W'(1);
          cmp_vld_d = 1'b1;
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      size_q      <= CNT_W'(DEPTH);
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      size_q      <= size_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      cmp_vld_q   <= cmp_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q       <= scan_d;
    iss_k_q      <= iss_k_d;
    cmp_k_q      <= cmp_k_d;
    key_q        <= key_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    res_pos_q    <= res_pos_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_data_q   <= res_data_q;
      out_pos_q    <= res_pos_q;
      out_occ_q    <= count_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_status_o    = out_status_q;
  assign out_data_o      = out_data_q;
  assign out_position_o  = out_pos_q;
  assign out_occupancy_o = out_occ_q;

  `CQS_ASSERT(a_count_in_size, clk_i, rst_ni, count_q <= size_q, "occupancy above capacity")
  `CQS_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_fire, !in_ready_o,
                   "ready right after an accepted transaction")
  `CQS_ASSERT_IMPL(a_pos_in_range, clk_i, rst_ni, out_valid_o && (out_position_o != '0),
                   (out_status_o == STATUS_OK) && (out_position_o <= out_occupancy_o),
                   "match position outside the held entries")
  `CQS_ASSERT_IMPL(a_count_moves_on_fire, clk_i, rst_ni, count_q != $past(count_q),
                   $past(in_fire) || $past(cfg_fire),
                   "occupancy changed without a transaction")

endmodule

`default_nettype wire
